// ===== hw/rtl/ptb_pkg.sv =====
// shared constants and codes for the periodic timer bank
package ptb_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int DELAY_BITS = 24;
    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [15:0] RUNS_FOREVER = 16'hFFFF;

    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_ALLOC    = 2'd1;
    localparam logic [1:0] REQ_SCHEDULE = 2'd2;
    localparam logic [1:0] REQ_CANCEL   = 2'd3;

    localparam logic [1:0] RES_FIRED = 2'd0;
    localparam logic [1:0] RES_ALLOC = 2'd1;
    localparam logic [1:0] RES_FULL  = 2'd2;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_TICK   = 3'd1;
    localparam logic [2:0] ST_FLUSH  = 3'd2;
    localparam logic [2:0] ST_ALLOC  = 3'd3;
    localparam logic [2:0] ST_CANCEL = 3'd4;

endpackage

// ===== hw/rtl/periodic_timer_bank.sv =====
// periodic timer bank: slot table, scan sequencer and result register
//
// Request channel (req_valid/req_ready) takes one word per request: tick,
// allocate, schedule or cancel. Result channel (res_valid/res_ready) gives
// result words; last_out marks the final word caused by a request.
// A tick walks all slots through one shared decrement/compare unit, one slot
// per cycle while the scan is not waiting on a stalled receiver, and then
// hands over the final firing, if any; it gives one word per firing slot, in
// slot order, or none.
// A cancel also walks the slots and gives no word. A schedule is written to
// the table as it is taken and gives no word. An allocate waits in the ALLOC
// state until the result register is free, then gives one word from that
// register: the slot, or table full.
// req_ready is high only while the sequencer is idle.
// Each firing is held in a pending register until the next firing or the end
// of the scan shows whether it is the last; when the receiver stalls with the
// result register full, the scan waits on the slot that fired.
// Reset empties the table: no slot allocated, none running.
module periodic_timer_bank
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [1:0]         req_type,
    input  logic [3:0]         slot_sel,
    input  logic [9:0]         owner_id,
    input  logic [23:0]        delay_ticks,
    input  logic signed [15:0] repeat_count,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [1:0]         result_kind,
    output logic [3:0]         slot_out,
    output logic [9:0]         owner_out,
    output logic               last_out
);

    localparam int NS = ptb_pkg::NUM_SLOTS;
    localparam int SW = ptb_pkg::SLOT_W;
    localparam int DB = ptb_pkg::DELAY_BITS;

    logic [2:0]    state_reg, state_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [9:0]    req_owner_reg, req_owner_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [SW-1:0] pend_slot_reg, pend_slot_next;
    logic [9:0]    pend_owner_reg, pend_owner_next;

    logic [NS-1:0] used_reg, used_next;
    logic [NS-1:0] running_reg, running_next;

    logic [DB-1:0] ticks_reg  [NS];
    logic [DB-1:0] reload_reg [NS];
    logic [15:0]   runs_reg   [NS];
    logic [9:0]    owner_reg  [NS];

    logic          res_valid_reg;
    logic [1:0]    result_kind_reg;
    logic [3:0]    slot_out_reg;
    logic [9:0]    owner_out_reg;
    logic          last_out_reg;

    // table write port
    logic          wr_cnt, wr_reload, wr_own;
    logic [SW-1:0] wr_addr;
    logic [DB-1:0] wr_ticks, wr_reload_val;
    logic [15:0]   wr_runs;
    logic [9:0]    wr_owner;

    // result emit
    logic          emit;
    logic [1:0]    emit_kind;
    logic [SW-1:0] emit_slot;
    logic [9:0]    emit_owner;
    logic          emit_last;

    logic          can_emit;
    logic          cur_active, cur_fire, at_end;
    logic [DB-1:0] cur_ticks;
    logic [15:0]   cur_runs, runs_dec;
    logic          free_found;
    logic [SW-1:0] free_idx;
    logic          req_fire;
    logic [SW-1:0] sel_idx;
    logic          sel_ok;

    assign req_ready = (state_reg == ptb_pkg::ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign can_emit  = !res_valid_reg || res_ready;
    assign at_end    = (idx_reg == SW'(NS - 1));

    assign cur_ticks  = ticks_reg[idx_reg];
    assign cur_runs   = runs_reg[idx_reg];
    assign runs_dec   = cur_runs - 16'd1;
    assign cur_active = used_reg[idx_reg] && running_reg[idx_reg];
    assign cur_fire   = cur_active && (cur_ticks <= DB'(1));

    assign sel_idx = SW'(slot_sel);
    assign sel_ok  = (32'(slot_sel) < NS) && used_reg[sel_idx] && !running_reg[sel_idx];

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        req_owner_next  = req_owner_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_owner_next = pend_owner_reg;
        used_next       = used_reg;
        running_next    = running_reg;

        wr_cnt        = 1'b0;
        wr_reload     = 1'b0;
        wr_own        = 1'b0;
        wr_addr       = idx_reg;
        wr_ticks      = '0;
        wr_reload_val = '0;
        wr_runs       = '0;
        wr_owner      = req_owner_reg;

        emit       = 1'b0;
        emit_kind  = ptb_pkg::RES_FIRED;
        emit_slot  = pend_slot_reg;
        emit_owner = pend_owner_reg;
        emit_last  = 1'b0;

        unique case (state_reg)
            ptb_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    req_owner_next = owner_id;
                    idx_next       = '0;
                    unique case (req_type)
                        ptb_pkg::REQ_TICK:   state_next = ptb_pkg::ST_TICK;
                        ptb_pkg::REQ_ALLOC:  state_next = ptb_pkg::ST_ALLOC;
                        ptb_pkg::REQ_CANCEL: state_next = ptb_pkg::ST_CANCEL;
                        ptb_pkg::REQ_SCHEDULE:
                        begin
                            if (sel_ok)
                            begin
                                wr_cnt        = 1'b1;
                                wr_reload     = 1'b1;
                                wr_addr       = sel_idx;
                                wr_ticks      = DB'(delay_ticks);
                                wr_reload_val = DB'(delay_ticks);
                                wr_runs       = repeat_count;
                                running_next[sel_idx] = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ptb_pkg::ST_TICK:
            begin
                // a new firing pushes out the pending one, so wait for room
                if (!(cur_fire && pend_valid_reg && !can_emit))
                begin
                    if (cur_active)
                    begin
                        wr_cnt = 1'b1;
                        if (cur_fire)
                        begin
                            wr_ticks = reload_reg[idx_reg];
                            wr_runs  = cur_runs;
                            if (cur_runs != ptb_pkg::RUNS_FOREVER)
                            begin
                                wr_runs = runs_dec;
                                if (runs_dec == 16'd0)
                                    running_next[idx_reg] = 1'b0;
                            end
                        end
                        else
                        begin
                            wr_ticks = cur_ticks - DB'(1);
                            wr_runs  = cur_runs;
                        end
                    end
                    if (cur_fire)
                    begin
                        emit            = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_slot_next  = idx_reg;
                        pend_owner_next = owner_reg[idx_reg];
                    end
                    if (at_end)
                        state_next = (cur_fire || pend_valid_reg) ? ptb_pkg::ST_FLUSH
                                                                  : ptb_pkg::ST_IDLE;
                    else
                        idx_next = idx_reg + SW'(1);
                end
            end

            ptb_pkg::ST_FLUSH:
            begin
                if (can_emit)
                begin
                    emit            = 1'b1;
                    emit_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ptb_pkg::ST_IDLE;
                end
            end

            ptb_pkg::ST_ALLOC:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    emit_owner = req_owner_reg;
                    if (free_found)
                    begin
                        emit_kind = ptb_pkg::RES_ALLOC;
                        emit_slot = free_idx;
                        wr_cnt    = 1'b1;
                        wr_reload = 1'b1;
                        wr_own    = 1'b1;
                        wr_addr   = free_idx;
                        used_next[free_idx]    = 1'b1;
                        running_next[free_idx] = 1'b0;
                    end
                    else
                    begin
                        emit_kind = ptb_pkg::RES_FULL;
                        emit_slot = '0;
                    end
                    state_next = ptb_pkg::ST_IDLE;
                end
            end

            ptb_pkg::ST_CANCEL:
            begin
                if (used_reg[idx_reg] && (owner_reg[idx_reg] == req_owner_reg))
                begin
                    used_next[idx_reg]    = 1'b0;
                    running_next[idx_reg] = 1'b0;
                end
                if (at_end)
                    state_next = ptb_pkg::ST_IDLE;
                else
                    idx_next = idx_reg + SW'(1);
            end

            default: state_next = ptb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ptb_pkg::ST_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            used_reg       <= '0;
            running_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            used_reg       <= used_next;
            running_reg    <= running_next;
            if (emit)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        req_owner_reg  <= req_owner_next;
        pend_slot_reg  <= pend_slot_next;
        pend_owner_reg <= pend_owner_next;
        if (wr_cnt)
        begin
            ticks_reg[wr_addr] <= wr_ticks;
            runs_reg[wr_addr]  <= wr_runs;
        end
        if (wr_reload)
            reload_reg[wr_addr] <= wr_reload_val;
        if (wr_own)
            owner_reg[wr_addr] <= wr_owner;
        if (emit)
        begin
            result_kind_reg <= emit_kind;
            slot_out_reg    <= 4'(emit_slot);
            owner_out_reg   <= emit_owner;
            last_out_reg    <= emit_last;
        end
    end

    assign res_valid   = res_valid_reg;
    assign result_kind = result_kind_reg;
    assign slot_out    = slot_out_reg;
    assign owner_out   = owner_out_reg;
    assign last_out    = last_out_reg;

endmodule

// ===== dv/periodic_timer_bank_tb.sv =====
// testbench for the periodic timer bank: random and directed requests checked against a slot table
module periodic_timer_bank_tb;

    localparam int MAX_WORDS    = 16;
    localparam int LONG_HOLD    = 300;
    localparam int TARGET_ITEMS = 200;
    localparam int CALM_ITEMS   = 160;

    typedef struct packed
    {
        logic [1:0] kind;
        logic [3:0] slot;
        logic [9:0] owner;
        logic       is_last;
    } timer_word_t;

    // shadow of the slot table plus the words it says are due
    class timer_slot_tracker;
        logic                           used      [ptb_pkg::NUM_SLOTS];
        logic                           running   [ptb_pkg::NUM_SLOTS];
        logic [ptb_pkg::DELAY_BITS-1:0] remaining [ptb_pkg::NUM_SLOTS];
        logic [ptb_pkg::DELAY_BITS-1:0] reload    [ptb_pkg::NUM_SLOTS];
        logic [15:0]                    runs      [ptb_pkg::NUM_SLOTS];
        logic [9:0]                     owner     [ptb_pkg::NUM_SLOTS];
        timer_word_t                    due_words [$];
        int                             mismatches;

        function new();
            foreach (used[i])
            begin
                used[i]      = 1'b0;
                running[i]   = 1'b0;
                remaining[i] = '0;
                reload[i]    = '0;
                runs[i]      = '0;
                owner[i]     = '0;
            end
            mismatches = 0;
        endfunction

        // returns 1 when the request changed the table or produced a word
        function bit apply_request(logic [1:0] kind, logic [3:0] sel, logic [9:0] who,
                                   logic [23:0] delay, logic [15:0] reps);
            timer_word_t batch [$];
            timer_word_t w;
            int          slot;
            bit          touched;
            touched = 1'b0;
            slot    = -1;
            case (kind)
                ptb_pkg::REQ_TICK:
                begin
                    for (int i = 0; i < ptb_pkg::NUM_SLOTS; i++)
                    begin
                        if (used[i] && running[i])
                        begin
                            touched = 1'b1;
                            if (remaining[i] <= 1)
                            begin
                                remaining[i] = reload[i];
                                if (runs[i] != ptb_pkg::RUNS_FOREVER)
                                begin
                                    runs[i] = runs[i] - 16'd1;
                                    if (runs[i] == 16'd0)
                                        running[i] = 1'b0;
                                end
                                if (batch.size() < MAX_WORDS)
                                begin
                                    w.kind    = ptb_pkg::RES_FIRED;
                                    w.slot    = 4'(i);
                                    w.owner   = owner[i];
                                    w.is_last = 1'b0;
                                    batch.push_back(w);
                                end
                            end
                            else
                                remaining[i] = remaining[i] - 1'b1;
                        end
                    end
                end
                ptb_pkg::REQ_ALLOC:
                begin
                    for (int i = 0; i < ptb_pkg::NUM_SLOTS; i++)
                    begin
                        if (!used[i] && slot < 0)
                            slot = i;
                    end
                    w.owner   = who;
                    w.is_last = 1'b0;
                    if (slot >= 0)
                    begin
                        used[slot]      = 1'b1;
                        running[slot]   = 1'b0;
                        remaining[slot] = '0;
                        reload[slot]    = '0;
                        runs[slot]      = '0;
                        owner[slot]     = who;
                        w.kind          = ptb_pkg::RES_ALLOC;
                        w.slot          = 4'(slot);
                    end
                    else
                    begin
                        w.kind = ptb_pkg::RES_FULL;
                        w.slot = '0;
                    end
                    batch.push_back(w);
                end
                ptb_pkg::REQ_SCHEDULE:
                begin
                    if (int'(sel) < ptb_pkg::NUM_SLOTS && used[sel] && !running[sel])
                    begin
                        remaining[sel] = delay[ptb_pkg::DELAY_BITS-1:0];
                        reload[sel]    = delay[ptb_pkg::DELAY_BITS-1:0];
                        runs[sel]      = reps;
                        running[sel]   = 1'b1;
                        touched        = 1'b1;
                    end
                end
                ptb_pkg::REQ_CANCEL:
                begin
                    foreach (used[i])
                    begin
                        if (used[i] && owner[i] == who)
                        begin
                            used[i]    = 1'b0;
                            running[i] = 1'b0;
                            touched    = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            if (batch.size() > 0)
                batch[$].is_last = 1'b1;
            foreach (batch[i])
                due_words.push_back(batch[i]);
            return touched || (batch.size() > 0);
        endfunction

        task report(string what);
            $display("%0t: mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_word(timer_word_t got);
            timer_word_t want;
            if (due_words.size() == 0)
                report($sformatf("word with none due: kind %0d slot %0d owner %0d last %0d",
                                 got.kind, got.slot, got.owner, got.is_last));
            else
            begin
                want = due_words.pop_front();
                if (got.kind != want.kind)
                    report($sformatf("result_kind %0d, want %0d", got.kind, want.kind));
                if (got.slot != want.slot)
                    report($sformatf("slot_out %0d, want %0d", got.slot, want.slot));
                if (got.owner != want.owner)
                    report($sformatf("owner_out %0d, want %0d", got.owner, want.owner));
                if (got.is_last != want.is_last)
                    report($sformatf("last_out %0d, want %0d", got.is_last, want.is_last));
            end
        endtask

        function int pick_stopped_slot();
            int cands [$];
            foreach (used[i])
            begin
                if (used[i] && !running[i])
                    cands.push_back(i);
            end
            if (cands.size() == 0)
                return -1;
            return cands[$urandom_range(0, cands.size() - 1)];
        endfunction

        function int free_slots();
            int n;
            n = 0;
            foreach (used[i])
            begin
                if (!used[i])
                    n++;
            end
            return n;
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    logic [1:0]         req_type;
    logic [3:0]         slot_sel;
    logic [9:0]         owner_id;
    logic [23:0]        delay_ticks;
    logic signed [15:0] repeat_count;
    logic               res_valid;
    logic               res_ready;
    logic [1:0]         result_kind;
    logic [3:0]         slot_out;
    logic [9:0]         owner_out;
    logic               last_out;

    timer_slot_tracker slots = new();
    timer_word_t       seen_word;
    int                sent_items;
    bit                calm;
    bit                hold_results;

    periodic_timer_bank dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .slot_sel     (slot_sel),
        .owner_id     (owner_id),
        .delay_ticks  (delay_ticks),
        .repeat_count (repeat_count),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .result_kind  (result_kind),
        .slot_out     (slot_out),
        .owner_out    (owner_out),
        .last_out     (last_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // called at a falling edge; returns at a falling edge after the word is taken, at times after a random pause
    task automatic offer_request(logic [1:0] kind, logic [3:0] sel, logic [9:0] who,
                                 logic [23:0] delay, logic [15:0] reps);
        req_valid    <= 1'b1;
        req_type     <= kind;
        slot_sel     <= sel;
        owner_id     <= who;
        delay_ticks  <= delay;
        repeat_count <= reps;
        do
            @(posedge clk);
        while (!req_ready);
        void'(slots.apply_request(kind, sel, who, delay, reps));
        sent_items++;
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (slots.due_words.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [9:0] pool_owner();
        case ($urandom_range(0, 7))
            0: return 10'd0;
            1: return 10'd1023;
            2: return 10'd5;
            3: return 10'd42;
            4: return 10'd512;
            5: return 10'd777;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [23:0] pick_delay();
        case ($urandom_range(0, 9))
            0: return 24'($urandom_range(0, 20));
            1: return 24'($urandom());
            default: return 24'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [15:0] pick_runs();
        case ($urandom_range(0, 9))
            0: return ptb_pkg::RUNS_FOREVER;
            1: return 16'd0;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 4));
        endcase
    endfunction

    // allocate until the table refuses once
    task automatic fill_table();
        while (slots.free_slots() > 0)
            offer_request(ptb_pkg::REQ_ALLOC, 4'($urandom()), pool_owner(), pick_delay(),
                          pick_runs());
        offer_request(ptb_pkg::REQ_ALLOC, 4'($urandom()), pool_owner(), pick_delay(),
                      pick_runs());
    endtask

    task automatic random_item();
        int unsigned pick;
        int          target;
        pick   = $urandom_range(0, 99);
        target = slots.pick_stopped_slot();
        if (pick < 32)
            offer_request(ptb_pkg::REQ_TICK, 4'($urandom()), 10'($urandom()), 24'($urandom()),
                          16'($urandom()));
        else if (pick < 52)
            offer_request(ptb_pkg::REQ_ALLOC, 4'($urandom()), pool_owner(), pick_delay(),
                          pick_runs());
        else if (pick < 74 && target >= 0)
            offer_request(ptb_pkg::REQ_SCHEDULE, 4'(target), 10'($urandom()), pick_delay(),
                          pick_runs());
        else if (pick < 84)
            offer_request(ptb_pkg::REQ_SCHEDULE, 4'($urandom()), 10'($urandom()),
                          24'($urandom()), 16'($urandom()));
        else if (pick < 97)
            offer_request(ptb_pkg::REQ_CANCEL, 4'($urandom()), pool_owner(), 24'($urandom()),
                          16'($urandom()));
        else
            fill_table();
    endtask

    // schedule a stopped slot, if any, to fire every tick, then keep ticking into a stalled receiver
    task automatic stall_receiver();
        int target;
        if (slots.free_slots() > 0)
            offer_request(ptb_pkg::REQ_ALLOC, 4'd0, 10'd3, 24'd0, 16'd0);
        target = slots.pick_stopped_slot();
        if (target >= 0)
            offer_request(ptb_pkg::REQ_SCHEDULE, 4'(target), 10'd0, 24'd0,
                          ptb_pkg::RUNS_FOREVER);
        hold_results = 1'b1;
        repeat (12)
            offer_request(ptb_pkg::REQ_TICK, 4'($urandom()), 10'($urandom()), 24'($urandom()),
                          16'($urandom()));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            seen_word.kind    = result_kind;
            seen_word.slot    = slot_out;
            seen_word.owner   = owner_out;
            seen_word.is_last = last_out;
            slots.check_word(seen_word);
        end
    end

    initial
    begin
        res_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                hold_results = 1'b0;
                res_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                res_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                res_ready <= 1'b1;
            end
            else
                res_ready <= 1'b1;
        end
    end

    initial
    begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        bit filled;
        bit stalled;
        bit drained;
        filled       = 1'b0;
        stalled      = 1'b0;
        drained      = 1'b0;
        sent_items   = 0;
        calm         = 1'b0;
        hold_results = 1'b0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_type     = ptb_pkg::REQ_TICK;
        slot_sel     = '0;
        owner_id     = '0;
        delay_ticks  = '0;
        repeat_count = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        offer_request(ptb_pkg::REQ_ALLOC, 4'd0, 10'd0, 24'd0, 16'd0);
        offer_request(ptb_pkg::REQ_ALLOC, 4'd0, 10'd1023, 24'd0, 16'd0);
        offer_request(ptb_pkg::REQ_ALLOC, 4'd0, 10'd5, 24'd0, 16'd0);
        offer_request(ptb_pkg::REQ_ALLOC, 4'd0, 10'd5, 24'd0, 16'd0);
        // zero delay, forever
        offer_request(ptb_pkg::REQ_SCHEDULE, 4'd0, 10'd0, 24'd0, ptb_pkg::RUNS_FOREVER);
        // already running, ignored
        offer_request(ptb_pkg::REQ_SCHEDULE, 4'd0, 10'd0, 24'd7, 16'd3);
        offer_request(ptb_pkg::REQ_SCHEDULE, 4'd1, 10'd0, 24'd1, 16'd2);
        // zero runs wraps to forever after the first firing
        offer_request(ptb_pkg::REQ_SCHEDULE, 4'd2, 10'd0, 24'd2, 16'd0);
        // slot never allocated, ignored
        offer_request(ptb_pkg::REQ_SCHEDULE, 4'd15, 10'd1023, 24'hFFFFFF, 16'h7FFF);
        offer_request(ptb_pkg::REQ_SCHEDULE, 4'd3, 10'd0, 24'hFFFFFF, 16'h8000);
        repeat (4)
            offer_request(ptb_pkg::REQ_TICK, 4'd0, 10'd0, 24'd0, 16'd0);
        offer_request(ptb_pkg::REQ_SCHEDULE, 4'd2, 10'd0, 24'd1, 16'd1);
        offer_request(ptb_pkg::REQ_CANCEL, 4'd0, 10'd5, 24'd0, 16'd0);
        offer_request(ptb_pkg::REQ_TICK, 4'd15, 10'd1023, 24'hFFFFFF, 16'hFFFF);
        offer_request(ptb_pkg::REQ_ALLOC, 4'd0, 10'h2AA, 24'd0, 16'd0);
        offer_request(ptb_pkg::REQ_SCHEDULE, 4'd2, 10'd0, 24'd3, 16'h7FFF);
        offer_request(ptb_pkg::REQ_TICK, 4'd0, 10'd0, 24'd0, 16'd0);
        offer_request(ptb_pkg::REQ_CANCEL, 4'd0, 10'd0, 24'd0, 16'd0);
        offer_request(ptb_pkg::REQ_CANCEL, 4'd0, 10'd1023, 24'd0, 16'd0);
        offer_request(ptb_pkg::REQ_CANCEL, 4'd0, 10'h2AA, 24'd0, 16'd0);
        offer_request(ptb_pkg::REQ_TICK, 4'd0, 10'd0, 24'd0, 16'd0);

        while (sent_items < TARGET_ITEMS)
        begin
            if (!filled && sent_items >= 30)
            begin
                filled = 1'b1;
                fill_table();
            end
            else if (!stalled && sent_items >= 60)
            begin
                stalled = 1'b1;
                stall_receiver();
            end
            else if (!drained && sent_items >= 120)
            begin
                drained = 1'b1;
                drain_results();
            end
            else
                random_item();
            if (sent_items >= CALM_ITEMS)
                calm = 1'b1;
        end

        drain_results();
        repeat (3 * ptb_pkg::NUM_SLOTS) @(negedge clk);
        if (slots.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ptb_pkg.sv
hw/rtl/periodic_timer_bank.sv
dv/periodic_timer_bank_tb.sv
